// File: hw/rtl/stl_pkg.sv
// shared types, token kinds, character codes and helpers for the script token lexer
`default_nettype none

package stl_pkg;

    // result queue sizing
    localparam int QUEUE_DEPTH = 8;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);

    // depth-zero number that marks a label
    localparam logic [15:0] LABEL_VALUE = 16'h0090;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UC_A   = 8'h41;
    localparam logic [7:0] CH_UC_Z   = 8'h5A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LC_A   = 8'h61;
    localparam logic [7:0] CH_LC_Z   = 8'h7A;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_TILDE  = 8'h7E;

    // token kinds
    typedef enum logic [3:0] {
        KIND_OPCODE   = 4'd0,
        KIND_LIBCALL  = 4'd1,
        KIND_OPEN     = 4'd2,
        KIND_CLOSE    = 4'd3,
        KIND_PIPE     = 4'd4,
        KIND_COMMA    = 4'd5,
        KIND_SEMI     = 4'd6,
        KIND_VALUE    = 4'd7,
        KIND_STRING   = 4'd8,
        KIND_INT      = 4'd9,
        KIND_INTLIT   = 4'd10,
        KIND_FLOATLIT = 4'd11,
        KIND_EOF      = 4'd12,
        KIND_ERROR    = 4'd13
    } t_kind;

    // one result beat
    typedef struct packed {
        t_kind       kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic [15:0] col;
        logic        label;
        logic [7:0]  depth;
        logic        last;
    } t_token;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z));
    endfunction

    function automatic logic is_single(input logic [7:0] c);
        return (c == CH_LT) || (c == CH_GT) || (c == CH_PIPE) || (c == CH_COMMA) ||
               (c == CH_SEMI);
    endfunction

    function automatic logic is_word_char(input logic [7:0] c);
        return (c != CH_NUL) && !is_single(c) && (c != CH_SPACE) && (c != CH_TAB) &&
               (c != CH_CR) && (c != CH_LF) && (c != CH_DQUOTE) && (c != CH_SQUOTE) &&
               (c != CH_AT) && (c != CH_DOLLAR);
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/script_token_lexer.sv
// top level of the script token lexer: byte stream in, token beats out
// flow: an accepted byte beat is held in the input register and scanned from there; its
//   tokens are written into the result queue, from whose head they are then taken
// throughput: one byte beat per cycle while o_stall is low; a byte that yields two tokens fills two output beats
// reset: synchronous active-low; scanner back to idle at offset 0, line 1, column 1,
//   result queue emptied; an end beat also returns the scanner to that state
`default_nettype none

module script_token_lexer #(
    parameter int OFFSET_BITS = 16,
    parameter int DEPTH_BITS  = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_source_byte,
    input  wire logic        i_end_of_source,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [3:0]       o_token_kind,
    output logic [15:0]      o_start_offset,
    output logic [15:0]      o_span_length,
    output logic [15:0]      o_line_number,
    output logic [15:0]      o_column_number,
    output logic             o_labels_seen,
    output logic [7:0]       o_open_depth,
    output logic             o_last_of_run
);

    logic [stl_pkg::CNT_W-1:0] fill;
    logic [1:0]                push;
    stl_pkg::t_token           tok0;
    stl_pkg::t_token           tok1;
    stl_pkg::t_token           head;

    // scanner
    stl_core #(
        .OFFSET_BITS (OFFSET_BITS),
        .DEPTH_BITS  (DEPTH_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_source_byte   (i_source_byte),
        .i_end_of_source (i_end_of_source),
        .i_fill          (fill),
        .o_push          (push),
        .o_tok0          (tok0),
        .o_tok1          (tok1)
    );

    // result queue
    stl_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_tok0  (tok0),
        .i_tok1  (tok1),
        .o_fill  (fill),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_tok   (head)
    );

    // output beat fields
    assign o_token_kind    = head.kind;
    assign o_start_offset  = head.start;
    assign o_span_length   = head.len;
    assign o_line_number   = head.line;
    assign o_column_number = head.col;
    assign o_labels_seen   = head.label;
    assign o_open_depth    = head.depth;
    assign o_last_of_run   = head.last;

endmodule

`default_nettype wire

// File: hw/rtl/stl_core.sv
// input register, scanner state and per-beat token decision for the script token lexer
`default_nettype none

module stl_core #(
    parameter int OFFSET_BITS = 16,
    parameter int DEPTH_BITS  = 8
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [7:0]                i_source_byte,
    input  wire logic                      i_end_of_source,
    input  wire logic [stl_pkg::CNT_W-1:0] i_fill,
    output logic [1:0]                     o_push,
    output stl_pkg::t_token                o_tok0,
    output stl_pkg::t_token                o_tok1
);

    localparam int OW = (OFFSET_BITS > 16) ? OFFSET_BITS : 16;
    localparam int DW = (DEPTH_BITS > 8) ? DEPTH_BITS : 8;

    typedef enum logic [3:0] {
        M_IDLE, M_COMMENT, M_MINUS, M_DOLLAR, M_AT, M_NUM, M_FRAC, M_LIB,
        M_INTLIT, M_FLT, M_FLTFRAC, M_IDENT, M_STRING, M_ESCAPE
    } t_mode;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] off;
        logic [15:0]            line;
        logic [15:0]            col;
    } t_pos;

    // step the position past one byte, all fields saturating
    function automatic t_pos pos_advance(input t_pos p, input logic [7:0] c);
        t_pos q;
        q = p;
        q.off = (&p.off) ? p.off : p.off + 1'b1;
        if (c == stl_pkg::CH_LF) begin
            q.line = stl_pkg::sat_inc16(p.line);
            q.col  = 16'd1;
        end else begin
            q.col = stl_pkg::sat_inc16(p.col);
        end
        return q;
    endfunction

    function automatic logic [15:0] sat_off(input logic [OFFSET_BITS-1:0] v);
        logic [OW-1:0] w;
        w = OW'(v);
        return (w > OW'(16'hFFFF)) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic [7:0] sat_depth(input logic [DEPTH_BITS-1:0] v);
        logic [DW-1:0] w;
        w = DW'(v);
        return (w > DW'(8'hFF)) ? 8'hFF : w[7:0];
    endfunction

    function automatic stl_pkg::t_token make_token(
        input stl_pkg::t_kind          kind,
        input logic [OFFSET_BITS-1:0]  start,
        input logic [OFFSET_BITS-1:0]  len,
        input logic [15:0]             line,
        input logic [15:0]             col,
        input logic                    label,
        input logic [DEPTH_BITS-1:0]   depth
    );
        stl_pkg::t_token t;
        t.kind  = kind;
        t.start = sat_off(start);
        t.len   = sat_off(len);
        t.line  = line;
        t.col   = col;
        t.label = label;
        t.depth = sat_depth(depth);
        t.last  = 1'b0;
        return t;
    endfunction

    // input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;

    // scanner state
    t_mode                  r_mode, n_mode;
    t_pos                   r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [15:0]            r_tline, n_tline;
    logic [15:0]            r_tcol, n_tcol;
    logic [DEPTH_BITS-1:0]  r_depth, n_depth;
    stl_pkg::t_kind         r_prev, n_prev;
    logic                   r_has_prev, n_has_prev;
    logic [15:0]            r_num, n_num;
    logic                   r_neg, n_neg;
    logic                   r_quote, n_quote;
    logic                   r_label, n_label;

    // token requests of the two phases
    logic                   e1_v, e2_v;
    stl_pkg::t_kind         e1_kind, e2_kind;
    logic [OFFSET_BITS-1:0] e1_start, e2_start, e1_len, e2_len;
    logic [15:0]            e1_line, e2_line, e1_col, e2_col;
    stl_pkg::t_token        tok_a, tok_b;
    logic [1:0]             push;

    // byte decision: current mode first, then a fresh scan from idle when needed
    always_comb begin
        logic [7:0]     c;
        logic           do_idle;
        logic           adv1;
        logic           num_done;
        logic [19:0]    nx;
        stl_pkg::t_kind sk;

        c          = r_byte;
        do_idle    = 1'b0;
        adv1       = 1'b0;
        num_done   = 1'b0;
        nx         = '0;
        sk         = stl_pkg::KIND_SEMI;
        n_mode     = r_mode;
        n_pos      = r_pos;
        n_start    = r_start;
        n_tline    = r_tline;
        n_tcol     = r_tcol;
        n_depth    = r_depth;
        n_prev     = r_prev;
        n_has_prev = r_has_prev;
        n_num      = r_num;
        n_neg      = r_neg;
        n_quote    = r_quote;
        n_label    = r_label;
        e1_v       = 1'b0;
        e1_kind    = stl_pkg::KIND_ERROR;
        e1_start   = r_start;
        e1_len     = r_pos.off - r_start;
        e1_line    = r_tline;
        e1_col     = r_tcol;
        e2_v       = 1'b0;
        e2_kind    = stl_pkg::KIND_ERROR;
        e2_start   = r_start;
        e2_len     = OFFSET_BITS'(1);
        e2_line    = r_pos.line;
        e2_col     = r_pos.col;

        // phase one: finish or continue the token in progress
        if (r_end) begin
            unique case (r_mode)
                M_MINUS, M_DOLLAR, M_AT: begin
                    e1_v    = 1'b1;
                    e1_len  = OFFSET_BITS'(1);
                    e1_line = r_pos.line;
                    e1_col  = r_pos.col;
                end
                M_NUM: begin
                    num_done = 1'b1;
                    e1_v     = 1'b1;
                    e1_kind  = (r_depth != '0) ? stl_pkg::KIND_INT : stl_pkg::KIND_OPCODE;
                end
                M_FRAC, M_IDENT: begin
                    e1_v    = 1'b1;
                    e1_kind = stl_pkg::KIND_VALUE;
                end
                M_LIB: begin
                    e1_v    = 1'b1;
                    e1_kind = stl_pkg::KIND_LIBCALL;
                end
                M_INTLIT: begin
                    e1_v    = 1'b1;
                    e1_kind = stl_pkg::KIND_INTLIT;
                end
                M_FLT, M_FLTFRAC: begin
                    e1_v    = 1'b1;
                    e1_kind = stl_pkg::KIND_FLOATLIT;
                end
                M_STRING, M_ESCAPE: begin
                    e1_v    = 1'b1;
                    e1_kind = stl_pkg::KIND_STRING;
                end
                M_IDLE, M_COMMENT: begin
                    e1_v = 1'b0;
                end
                default: begin
                    e1_v = 1'b0;
                end
            endcase
        end else begin
            unique case (r_mode)
                M_COMMENT: begin
                    if (c == stl_pkg::CH_LF) do_idle = 1'b1;
                    else adv1 = 1'b1;
                end
                M_MINUS: begin
                    if (c == stl_pkg::CH_MINUS) begin
                        adv1   = 1'b1;
                        n_mode = M_COMMENT;
                    end else if (stl_pkg::is_digit(c)) begin
                        n_neg  = 1'b1;
                        n_num  = {12'd0, c[3:0]};
                        adv1   = 1'b1;
                        n_mode = M_NUM;
                    end else begin
                        e1_v    = 1'b1;
                        e1_len  = OFFSET_BITS'(1);
                        e1_line = r_pos.line;
                        e1_col  = r_pos.col;
                        do_idle = 1'b1;
                    end
                end
                M_DOLLAR, M_AT: begin
                    if (stl_pkg::is_digit(c)) begin
                        adv1   = 1'b1;
                        n_mode = (r_mode == M_DOLLAR) ? M_INTLIT : M_FLT;
                    end else begin
                        e1_v    = 1'b1;
                        e1_len  = OFFSET_BITS'(1);
                        e1_line = r_pos.line;
                        e1_col  = r_pos.col;
                        do_idle = 1'b1;
                    end
                end
                M_NUM: begin
                    if (stl_pkg::is_digit(c)) begin
                        nx    = ({4'd0, r_num} << 3) + ({4'd0, r_num} << 1) + {16'd0, c[3:0]};
                        n_num = (nx > 20'h0FFFF) ? 16'hFFFF : nx[15:0];
                        adv1  = 1'b1;
                    end else begin
                        num_done = 1'b1;
                        if (c == stl_pkg::CH_DOT) begin
                            adv1   = 1'b1;
                            n_mode = M_FRAC;
                        end else if (c == stl_pkg::CH_TILDE) begin
                            adv1   = 1'b1;
                            n_mode = M_LIB;
                        end else begin
                            e1_v    = 1'b1;
                            e1_kind = ((r_depth != '0) && (c != stl_pkg::CH_LT)) ?
                                      stl_pkg::KIND_INT : stl_pkg::KIND_OPCODE;
                            do_idle = 1'b1;
                        end
                    end
                end
                M_FRAC, M_INTLIT, M_FLTFRAC: begin
                    if (stl_pkg::is_digit(c)) begin
                        adv1 = 1'b1;
                    end else begin
                        e1_v    = 1'b1;
                        e1_kind = (r_mode == M_FRAC)   ? stl_pkg::KIND_VALUE  :
                                  (r_mode == M_INTLIT) ? stl_pkg::KIND_INTLIT :
                                                         stl_pkg::KIND_FLOATLIT;
                        do_idle = 1'b1;
                    end
                end
                M_FLT: begin
                    if (stl_pkg::is_digit(c)) begin
                        adv1 = 1'b1;
                    end else if (c == stl_pkg::CH_DOT) begin
                        adv1   = 1'b1;
                        n_mode = M_FLTFRAC;
                    end else begin
                        e1_v    = 1'b1;
                        e1_kind = stl_pkg::KIND_FLOATLIT;
                        do_idle = 1'b1;
                    end
                end
                M_LIB, M_IDENT: begin
                    if (stl_pkg::is_word_char(c)) begin
                        adv1 = 1'b1;
                    end else begin
                        e1_v    = 1'b1;
                        e1_kind = (r_mode == M_LIB) ? stl_pkg::KIND_LIBCALL : stl_pkg::KIND_VALUE;
                        do_idle = 1'b1;
                    end
                end
                M_STRING: begin
                    adv1 = 1'b1;
                    if (c == (r_quote ? stl_pkg::CH_SQUOTE : stl_pkg::CH_DQUOTE)) begin
                        e1_v    = 1'b1;
                        e1_kind = stl_pkg::KIND_STRING;
                        n_mode  = M_IDLE;
                    end else if (c == stl_pkg::CH_BSLASH) begin
                        n_mode = M_ESCAPE;
                    end
                end
                M_ESCAPE: begin
                    adv1   = 1'b1;
                    n_mode = M_STRING;
                end
                M_IDLE: begin
                    do_idle = 1'b1;
                end
                default: begin
                    do_idle = 1'b1;
                end
            endcase
        end

        // label check happens before the number token goes out
        if (num_done && (r_depth == '0) && !r_neg && (r_num == stl_pkg::LABEL_VALUE)) begin
            n_label = 1'b1;
        end
        if (adv1) n_pos = pos_advance(n_pos, c);
        if (e1_v) begin
            n_prev     = e1_kind;
            n_has_prev = 1'b1;
        end
        tok_a = make_token(e1_kind, e1_start, e1_len, e1_line, e1_col, n_label, n_depth);

        // phase two: end-of-source token, or a fresh scan of this byte
        if (r_end) begin
            e2_v     = 1'b1;
            e2_kind  = stl_pkg::KIND_EOF;
            e2_start = n_pos.off;
            e2_len   = '0;
            e2_line  = n_pos.line;
            e2_col   = n_pos.col;
        end else if (do_idle) begin
            n_mode = M_IDLE;
            if (stl_pkg::is_space(c)) begin
                n_pos = pos_advance(n_pos, c);
            end else begin
                n_start = n_pos.off;
                n_tline = n_pos.line;
                n_tcol  = n_pos.col;
                n_pos   = pos_advance(n_pos, c);
                e2_start = n_start;
                e2_line  = n_pos.line;
                e2_col   = n_pos.col;
                if (c == stl_pkg::CH_MINUS) begin
                    n_mode = M_MINUS;
                end else if (stl_pkg::is_single(c)) begin
                    if (c == stl_pkg::CH_LT) sk = stl_pkg::KIND_OPEN;
                    else if (c == stl_pkg::CH_GT) sk = stl_pkg::KIND_CLOSE;
                    else if (c == stl_pkg::CH_PIPE) sk = stl_pkg::KIND_PIPE;
                    else if (c == stl_pkg::CH_COMMA) sk = stl_pkg::KIND_COMMA;
                    else sk = stl_pkg::KIND_SEMI;
                    e2_v = 1'b1;
                    if (((sk == stl_pkg::KIND_COMMA) || (sk == stl_pkg::KIND_CLOSE)) &&
                        n_has_prev &&
                        ((n_prev == stl_pkg::KIND_COMMA) || (n_prev == stl_pkg::KIND_OPEN))) begin
                        e2_kind = stl_pkg::KIND_ERROR;
                    end else if ((sk == stl_pkg::KIND_CLOSE) && (n_depth == '0)) begin
                        e2_kind = stl_pkg::KIND_ERROR;
                    end else begin
                        if ((sk == stl_pkg::KIND_OPEN) && !(&n_depth)) n_depth = n_depth + 1'b1;
                        if (sk == stl_pkg::KIND_CLOSE) n_depth = n_depth - 1'b1;
                        e2_kind = sk;
                        e2_line = n_tline;
                        e2_col  = n_tcol;
                    end
                end else if (stl_pkg::is_digit(c)) begin
                    n_neg  = 1'b0;
                    n_num  = {12'd0, c[3:0]};
                    n_mode = M_NUM;
                end else if ((c == stl_pkg::CH_DQUOTE) || (c == stl_pkg::CH_SQUOTE)) begin
                    // string span starts after the quote
                    n_quote = (c == stl_pkg::CH_SQUOTE);
                    n_start = n_pos.off;
                    n_tline = n_pos.line;
                    n_tcol  = n_pos.col;
                    n_mode  = M_STRING;
                end else if (c == stl_pkg::CH_DOLLAR) begin
                    n_mode = M_DOLLAR;
                end else if (c == stl_pkg::CH_AT) begin
                    n_mode = M_AT;
                end else if (stl_pkg::is_alpha(c) || (c == stl_pkg::CH_UNDER)) begin
                    n_mode = M_IDENT;
                end else begin
                    e2_v    = 1'b1;
                    e2_kind = stl_pkg::KIND_ERROR;
                end
            end
        end
        if (e2_v) begin
            n_prev     = e2_kind;
            n_has_prev = 1'b1;
        end
        tok_b = make_token(e2_kind, e2_start, e2_len, e2_line, e2_col, n_label, n_depth);

        // everything returns to reset once the end token is out
        if (r_end) begin
            n_mode     = M_IDLE;
            n_pos.off  = '0;
            n_pos.line = 16'd1;
            n_pos.col  = 16'd1;
            n_start    = '0;
            n_tline    = 16'd1;
            n_tcol     = 16'd1;
            n_depth    = '0;
            n_prev     = stl_pkg::KIND_OPCODE;
            n_has_prev = 1'b0;
            n_num      = '0;
            n_neg      = 1'b0;
            n_quote    = 1'b0;
            n_label    = 1'b0;
        end
    end

    // pack the beats for the result queue
    always_comb begin
        push = r_in_valid ? ({1'b0, e1_v} + {1'b0, e2_v}) : 2'd0;
        if (e1_v) begin
            o_tok0      = tok_a;
            o_tok0.last = !e2_v;
        end else begin
            o_tok0      = tok_b;
            o_tok0.last = 1'b1;
        end
        o_tok1      = tok_b;
        o_tok1.last = 1'b1;
    end

    assign o_push  = push;
    // room for this beat's results plus two more from the next one
    assign o_stall = ({1'b0, i_fill} + (stl_pkg::CNT_W + 1)'(push)) >
                     (stl_pkg::CNT_W + 1)'(stl_pkg::QUEUE_DEPTH - 2);

    // input register payload
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_byte <= i_source_byte;
            r_end  <= i_end_of_source;
        end
    end

    // control and scanner state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= M_IDLE;
            r_pos.off  <= '0;
            r_pos.line <= 16'd1;
            r_pos.col  <= 16'd1;
            r_start    <= '0;
            r_tline    <= 16'd1;
            r_tcol     <= 16'd1;
            r_depth    <= '0;
            r_prev     <= stl_pkg::KIND_OPCODE;
            r_has_prev <= 1'b0;
            r_num      <= '0;
            r_neg      <= 1'b0;
            r_quote    <= 1'b0;
            r_label    <= 1'b0;
        end else begin
            r_in_valid <= i_valid && !o_stall;
            if (r_in_valid) begin
                r_mode     <= n_mode;
                r_pos      <= n_pos;
                r_start    <= n_start;
                r_tline    <= n_tline;
                r_tcol     <= n_tcol;
                r_depth    <= n_depth;
                r_prev     <= n_prev;
                r_has_prev <= n_has_prev;
                r_num      <= n_num;
                r_neg      <= n_neg;
                r_quote    <= n_quote;
                r_label    <= n_label;
            end
        end
    end

    // an end beat leaves the scanner in its reset state
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_end) |=> (r_mode == M_IDLE && r_pos.off == '0 && r_depth == '0))
        else $error("scanner state not cleared after end beat");

    // line and column counters never reach zero
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pos.line != 16'd0) && (r_pos.col != 16'd0) && (r_tline != 16'd0))
        else $error("line or column counter reached zero");

    // a processed beat always fits in the result queue
    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |-> (({1'b0, i_fill} + (stl_pkg::CNT_W + 1)'(push)) <=
                        (stl_pkg::CNT_W + 1)'(stl_pkg::QUEUE_DEPTH)))
        else $error("result queue overflow");

endmodule

`default_nettype wire

// File: hw/rtl/stl_out_fifo.sv
// result queue of the script token lexer: takes up to two tokens a cycle, hands out one unless stalled
`default_nettype none

module stl_out_fifo (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic [1:0]                i_push,
    input  wire stl_pkg::t_token           i_tok0,
    input  wire stl_pkg::t_token           i_tok1,
    output logic [stl_pkg::CNT_W-1:0]      o_fill,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output stl_pkg::t_token                o_tok
);

    stl_pkg::t_token             r_mem [stl_pkg::QUEUE_DEPTH];
    logic [stl_pkg::PTR_W-1:0]   r_wr_ptr;
    logic [stl_pkg::PTR_W-1:0]   r_rd_ptr;
    logic [stl_pkg::CNT_W-1:0]   r_count;
    logic                        pop;

    assign o_valid = (r_count != '0);
    assign pop     = o_valid && !i_stall;
    assign o_tok   = r_mem[r_rd_ptr];
    assign o_fill  = r_count;

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) r_mem[r_wr_ptr] <= i_tok0;
        if (i_push == 2'd2) r_mem[r_wr_ptr + 1'b1] <= i_tok1;
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + stl_pkg::PTR_W'(i_push);
            r_rd_ptr <= r_rd_ptr + stl_pkg::PTR_W'(pop);
            r_count  <= r_count + stl_pkg::CNT_W'(i_push) - stl_pkg::CNT_W'(pop);
        end
    end

    // fill count stays within the queue
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= stl_pkg::CNT_W'(stl_pkg::QUEUE_DEPTH))
        else $error("result queue fill count out of range");

    // a push with no pop grows the fill count
    a_fill_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push != 2'd0 && !pop) |=> (r_count > $past(r_count)))
        else $error("result queue fill count did not grow on push");

endmodule

`default_nettype wire
